[rtl/fcsg_pkg.sv]
// Package for the filled circle span generator.
// Field widths, iteration bounds and the controller/datapath link types.
// No dependencies.
`default_nettype none

package fcsg_pkg;

  localparam int CENTER_W    = 10;
  localparam int RADIUS_W    = 6;
  localparam int COORD_W     = 12;
  localparam int LEN_W       = 7;
  localparam int STEP_W      = 8;   // signed x / y, room for x going below zero
  localparam int ERR_W       = 10;  // signed midpoint error
  localparam int MAX_RESULTS = 46;
  localparam int CNT_W       = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [LEN_W-1:0]   len_t;
  typedef logic signed [STEP_W-1:0]  step_t;
  typedef logic signed [ERR_W-1:0]   err_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/fcsg_if.sv]
// Channel interfaces for the filled circle span generator.
// Depends on fcsg_pkg.
`default_nettype none

interface fcsg_in_if;
  import fcsg_pkg::*;

  logic                valid;
  logic                ready;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [RADIUS_W-1:0] radius;

  modport source (output valid, center_x, center_y, radius, input ready);
  modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

interface fcsg_out_if;
  import fcsg_pkg::*;

  logic   valid;
  logic   ready;
  coord_t near_start;
  coord_t near_row_low;
  coord_t near_row_high;
  len_t   near_length;
  coord_t far_start;
  coord_t far_row_low;
  coord_t far_row_high;
  len_t   far_length;
  logic   far_valid;
  logic   last;

  modport source (output valid, near_start, near_row_low, near_row_high, near_length,
                  far_start, far_row_low, far_row_high, far_length, far_valid, last,
                  input ready);
  modport sink   (input valid, near_start, near_row_low, near_row_high, near_length,
                  far_start, far_row_low, far_row_high, far_length, far_valid, last,
                  output ready);
endinterface

`default_nettype wire

[rtl/fcsg_ctrl.sv]
// Controller for the filled circle span generator: idle/run sequencing.
// Depends on fcsg_pkg and fcsg_in_if.
`default_nettype none

module fcsg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  fcsg_in_if.sink            in_ch,
  input  fcsg_pkg::dp_sts_t  sts,
  output fcsg_pkg::ctrl_cmd_t cmd
);
  import fcsg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign cmd.load    = in_ch.valid && (state_r == ST_IDLE);
  assign cmd.step    = (state_r == ST_RUN) && sts.slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/fcsg_dp.sv]
// Datapath for the filled circle span generator: midpoint loop state,
// span arithmetic and the result register. Depends on fcsg_pkg and fcsg_if.
`default_nettype none

module fcsg_dp #(
  parameter int MAX_RADIUS = 63,
  parameter int COORD_BITS = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  fcsg_in_if.sink             in_ch,
  fcsg_out_if.source          out_ch,
  input  fcsg_pkg::ctrl_cmd_t cmd,
  output fcsg_pkg::dp_sts_t   sts
);
  import fcsg_pkg::*;

  localparam logic [CENTER_W-1:0] CMASK =
    CENTER_W'((64'd1 << COORD_BITS) - 64'd1);

  err_t                err_r, err_nxt;
  step_t               x_r, x_nxt;
  step_t               y_r, y_nxt;
  logic [CENTER_W-1:0] cx_r, cy_r;
  logic [CNT_W-1:0]    cnt_r;
  step_t               r_sat;
  err_t                e1;
  logic                far;
  logic                last_c;
  coord_t              cx_s, cy_s, x_s, y_s;
  logic                out_valid_r;

  always_comb begin
    if (32'(in_ch.radius) > MAX_RADIUS) begin
      r_sat = STEP_W'(MAX_RADIUS);
    end else begin
      r_sat = STEP_W'(in_ch.radius);
    end
  end

  // one midpoint step
  always_comb begin
    y_nxt = y_r + STEP_W'(1);
    e1    = err_r + ERR_W'(y_r) + ERR_W'(y_nxt);
    if (e1 >= 0) begin
      x_nxt   = x_r - STEP_W'(1);
      err_nxt = e1 - ERR_W'(x_r) - ERR_W'(x_nxt);
    end else begin
      x_nxt   = x_r;
      err_nxt = e1;
    end
  end

  assign last_c = (cnt_r == CNT_W'(MAX_RESULTS - 1)) || (y_nxt > x_nxt);
  assign far    = (x_r != y_r);
  assign cx_s   = coord_t'({{(COORD_W-CENTER_W){1'b0}}, cx_r});
  assign cy_s   = coord_t'({{(COORD_W-CENTER_W){1'b0}}, cy_r});
  assign x_s    = COORD_W'(x_r);
  assign y_s    = COORD_W'(y_r);

  assign sts.slot_free = !out_valid_r || out_ch.ready;
  assign sts.last      = last_c;
  assign out_ch.valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r  <= in_ch.center_x & CMASK;
      cy_r  <= in_ch.center_y & CMASK;
      x_r   <= r_sat;
      y_r   <= '0;
      err_r <= -ERR_W'(r_sat);
      cnt_r <= '0;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_ch.near_start    <= cx_s - x_s;
      out_ch.near_row_low  <= cy_s + y_s;
      out_ch.near_row_high <= cy_s - y_s;
      out_ch.near_length   <= LEN_W'({x_r, 1'b1});
      out_ch.far_start     <= far ? cx_s - y_s : '0;
      out_ch.far_row_low   <= far ? cy_s + x_s : '0;
      out_ch.far_row_high  <= far ? cy_s - x_s : '0;
      out_ch.far_length    <= far ? LEN_W'({y_r, 1'b1}) : '0;
      out_ch.far_valid     <= far;
      out_ch.last          <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/filled_circle_span_generator_core.sv]
// A circle of radius r (saturated to MAX_RADIUS) gives one transaction per
// midpoint iteration, about r/1.414 + 1 of them and at most 46, each carrying
// the near and far span pairs and a last flag on the final one. The
// iteration unit emits one transaction per cycle while the output register
// is free, after the circle has been loaded; a new circle is taken once the
// previous one has emitted its last result, even while that result still
// waits in the output register.
// Top level of the filled circle span generator.
// Depends on fcsg_pkg, fcsg_if, fcsg_ctrl and fcsg_dp.
`default_nettype none

module filled_circle_span_generator_core #(
  parameter int MAX_RADIUS = 63,
  parameter int COORD_BITS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcsg_in_if.sink    in_ch,
  fcsg_out_if.source out_ch
);
  import fcsg_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  fcsg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .sts   (sts),
    .cmd   (cmd)
  );

  fcsg_dp #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire
